// ===== hw/rtl/pcbp_pkg.sv =====
// Shared types and constants of the prefix-code bit packer.
package pcbp_pkg;

  localparam int OUT_W       = 8;
  localparam int SYM_W       = 8;
  localparam int LEN_W       = 6;
  localparam int CODE_W      = 32;
  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_FLUSH  = 2'd2
  } req_type_t;

  // Control of one request handed from the lookup stage to the packer.
  typedef struct packed {
    logic valid;
    logic flush;
  } pk_ctrl_t;

endpackage

// ===== hw/rtl/pcbp_table.sv =====
// Code table memory with post-reset clearing sweep and registered read port.
module pcbp_table
  import pcbp_pkg::*;
#(
  parameter int TABLE_DEPTH  = 256,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 wr_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0]       wr_addr,
  input  logic [$clog2(MAX_CODE_LEN+1)-1:0]    wr_len,
  input  logic [MAX_CODE_LEN-1:0]              wr_code,
  input  logic                                 rd_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0]       rd_addr,
  output logic [$clog2(MAX_CODE_LEN+1)-1:0]    rd_len,
  output logic [MAX_CODE_LEN-1:0]              rd_code,
  output logic                                 busy
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int LW = $clog2(MAX_CODE_LEN + 1);
  localparam int EW = LW + MAX_CODE_LEN;

  logic [EW-1:0] mem_r [TABLE_DEPTH];
  logic [EW-1:0] rd_data_r;
  logic          clr_r;
  logic          clr_nxt;
  logic [AW-1:0] clr_addr_r;
  logic [AW-1:0] clr_addr_nxt;

  always_comb begin
    clr_nxt      = clr_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_r) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(TABLE_DEPTH - 1)) begin
        clr_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_r      <= clr_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Single write port: the clearing sweep owns it until it finishes.
  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem_r[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem_r[wr_addr] <= {wr_len, wr_code};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_len  = rd_data_r[EW-1 -: LW];
  assign rd_code = rd_data_r[MAX_CODE_LEN-1:0];
  assign busy    = clr_r;

  a_no_access_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !wr_en && !rd_en)
    else $error("table accessed during clearing sweep");

  a_sweep_ends: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r && clr_addr_r == AW'(TABLE_DEPTH - 1) |=> !clr_r)
    else $error("clearing sweep did not stop at last entry");

  a_sweep_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_r |=> !clr_r)
    else $error("clearing sweep restarted without reset");

endmodule

// ===== hw/rtl/pcbp_packer.sv =====
// Byte packer: merges pending bits with a code and emits one byte per cycle while the output is ready.
module pcbp_packer
  import pcbp_pkg::*;
#(
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pk_ctrl_t                             ctrl,
  input  logic [$clog2(MAX_CODE_LEN+1)-1:0]    len,
  input  logic [MAX_CODE_LEN-1:0]              code,
  output logic                                 take,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [OUT_TDATA_W-1:0]               out_tdata,
  output logic                                 out_tlast
);

  localparam int LW   = $clog2(MAX_CODE_LEN + 1);
  localparam int TW   = LW + 1;
  localparam int SW   = OUT_W + MAX_CODE_LEN;
  localparam int MAXR = (OUT_W - 1 + MAX_CODE_LEN) / OUT_W;
  localparam int RW   = $clog2(MAXR + 1);

  logic [SW-1:0]          w_r;
  logic [SW-1:0]          w_nxt;
  logic [RW-1:0]          rem_r;
  logic [RW-1:0]          rem_nxt;
  logic [2:0]             cnt_r;
  logic [2:0]             cnt_nxt;
  logic                   out_tvalid_r;
  logic [OUT_W-1:0]       out_tdata_r;
  logic                   out_tlast_r;
  logic                   emit;
  logic                   load;
  logic [OUT_W-1:0]       acc;
  logic [SW-1:0]          stream;
  logic [TW-1:0]          total;

  assign emit = (rem_r != '0) && (!out_tvalid_r || out_tready);
  assign take = (rem_r == '0) || (rem_r == RW'(1) && emit);
  assign load = ctrl.valid && take;

  // Pending bits sit in the top byte once every full byte has left.
  assign acc    = (rem_r == '0) ? w_r[SW-1 -: OUT_W] : w_r[SW-1-OUT_W -: OUT_W];
  assign total  = TW'(cnt_r) + TW'(len);
  assign stream = {acc, {MAX_CODE_LEN{1'b0}}} |
                  (ctrl.flush ? '0 : ({code, {OUT_W{1'b0}}} >> cnt_r));

  always_comb begin
    w_nxt   = w_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (load) begin
      w_nxt = stream;
      if (ctrl.flush) begin
        rem_nxt = (cnt_r != 3'd0) ? RW'(1) : '0;
        cnt_nxt = 3'd0;
      end else begin
        rem_nxt = RW'(total >> 3);
        cnt_nxt = total[2:0];
      end
    end else if (emit) begin
      w_nxt   = w_r << OUT_W;
      rem_nxt = rem_r - RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r          <= '0;
      rem_r        <= '0;
      cnt_r        <= 3'd0;
      out_tvalid_r <= 1'b0;
    end else begin
      w_r   <= w_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_nxt;
      if (emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_tdata_r <= w_r[SW-1 -: OUT_W];
      out_tlast_r <= (rem_r == RW'(1));
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  a_flush_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    load && ctrl.flush |=> cnt_r == 3'd0 && rem_r <= RW'(1))
    else $error("flush left pending bits");

  a_last_byte_marked: assert property (@(posedge clk) disable iff (!rst_n)
    emit && rem_r == RW'(1) |=> out_tvalid_r && out_tlast_r)
    else $error("final byte of a transaction not marked last");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= RW'(MAXR))
    else $error("byte count exceeds bound");

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    load && rem_r != '0 |-> rem_r == RW'(1) && emit)
    else $error("new code loaded over unsent bytes");

endmodule

// ===== hw/rtl/prefix_code_bit_packer.sv =====
// Prefix-code bit packer top level: request decode, table lookup stage, packer.
// The first byte of an encode or flush passes the lookup stage, the packer shift
// register and the output byte register. A request emits up to 4 bytes for 32-bit
// codes; the packer sends one byte per cycle from its shift register unless the
// output stalls. Reset: synchronous, active low; afterwards the table is swept to
// zero length, with in_tready low, before the first request is taken.
module prefix_code_bit_packer
  import pcbp_pkg::*;
#(
  parameter int TABLE_DEPTH  = 256,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [IN_TDATA_W-1:0]   in_tdata,   // symbol, code_len, code_bits, zero pad
  input  logic [IN_TUSER_W-1:0]   in_tuser,   // req_type
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_TDATA_W-1:0]  out_tdata,  // out_byte
  output logic                    out_tlast
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int LW  = $clog2(MAX_CODE_LEN + 1);
  localparam int XW  = MAX_CODE_LEN + CODE_W;
  localparam int SXW = (AW > SYM_W) ? AW : SYM_W;

  req_type_t                req;
  logic [SYM_W-1:0]         sym;
  logic [LEN_W-1:0]         code_len;
  logic [CODE_W-1:0]        code_bits;
  logic [SXW-1:0]           sym_x;
  logic [AW-1:0]            addr;
  logic                     in_range;
  logic                     accept;
  logic                     wr_en;
  logic                     rd_en;
  logic [LW-1:0]            len_sat;
  logic [LW-1:0]            shamt;
  logic [XW-1:0]            code_shift;
  logic [LW-1:0]            rd_len;
  logic [MAX_CODE_LEN-1:0]  rd_code;
  logic                     tbl_busy;
  logic                     pk_take;
  pk_ctrl_t                 pk_ctrl;
  logic                     s1_valid_r;
  logic                     s1_valid_nxt;
  logic                     s1_flush_r;
  logic                     s1_inr_r;
  logic                     s1_start;

  assign req       = req_type_t'(in_tuser);
  assign sym       = in_tdata[SYM_W-1:0];
  assign code_len  = in_tdata[SYM_W+LEN_W-1:SYM_W];
  assign code_bits = in_tdata[SYM_W+LEN_W+CODE_W-1:SYM_W+LEN_W];

  assign sym_x    = SXW'(sym);
  assign addr     = sym_x[AW-1:0];
  assign in_range = {{(32-SYM_W){1'b0}}, sym} < 32'(TABLE_DEPTH);

  assign in_tready = !tbl_busy && (!s1_valid_r || pk_take);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    s1_start = 1'b0;
    case (req)
      REQ_LOAD: begin
        wr_en = accept && in_range;
      end
      REQ_ENCODE: begin
        rd_en    = accept && in_range;
        s1_start = accept;
      end
      REQ_FLUSH: begin
        s1_start = accept;
      end
      default: begin
        s1_start = 1'b0;
      end
    endcase
  end

  // Saturate the length and store the code left aligned in the entry.
  assign len_sat    = ({1'b0, code_len} > 7'(MAX_CODE_LEN)) ? LW'(MAX_CODE_LEN)
                                                            : LW'(code_len);
  assign shamt      = LW'(MAX_CODE_LEN) - len_sat;
  assign code_shift = XW'(code_bits) << shamt;

  pcbp_table #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_len  (len_sat),
    .wr_code (code_shift[MAX_CODE_LEN-1:0]),
    .rd_en   (rd_en),
    .rd_addr (addr),
    .rd_len  (rd_len),
    .rd_code (rd_code),
    .busy    (tbl_busy)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_start) begin
      s1_valid_nxt = 1'b1;
    end else if (pk_take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_flush_r <= 1'b0;
      s1_inr_r   <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (s1_start) begin
        s1_flush_r <= (req == REQ_FLUSH);
        s1_inr_r   <= in_range;
      end
    end
  end

  assign pk_ctrl.valid = s1_valid_r;
  assign pk_ctrl.flush = s1_flush_r;

  // An out-of-range symbol encodes as an empty code.
  pcbp_packer #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_packer (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (pk_ctrl),
    .len        (s1_inr_r ? rd_len : '0),
    .code       (s1_inr_r ? rd_code : '0),
    .take       (pk_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== sim/pcbp_byte_checker.sv =====
// Stream checker for the prefix-code bit packer: predicts packed bytes and compares them.
module pcbp_byte_checker
  import pcbp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // symbol, code_len, code_bits, zero pad
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // req_type
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // out_byte
  input  logic                   out_tlast,
  output int                     error_count,
  output int                     pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SIZE = 256;
  localparam int CODE_LIMIT = 32;

  typedef struct packed {
    logic [OUT_W-1:0] data;
    logic             last;
  } packed_byte_t;

  logic [LEN_W-1:0]  len_table  [TABLE_SIZE];
  logic [CODE_W-1:0] code_table [TABLE_SIZE];
  logic [OUT_W-1:0]  acc_bits;
  logic [2:0]        acc_count;
  packed_byte_t      expected_bytes[$];

  task automatic pack_request(input logic [1:0] req, input logic [SYM_W-1:0] sym,
                              input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] code);
    int           first_idx;
    int           i;
    packed_byte_t fresh;
    first_idx = expected_bytes.size();
    case (req)
      REQ_LOAD: begin
        len_table[sym]  = (len > LEN_W'(CODE_LIMIT)) ? LEN_W'(CODE_LIMIT) : len;
        code_table[sym] = code;
      end
      REQ_ENCODE: begin
        for (i = int'(len_table[sym]); i > 0; i--) begin
          acc_bits[3'd7 - acc_count] = code_table[sym][i-1];
          if (acc_count == 3'd7) begin
            fresh = '{acc_bits, 1'b0};
            expected_bytes.insert(expected_bytes.size(), fresh);
            acc_bits  = '0;
            acc_count = '0;
          end else begin
            acc_count = acc_count + 3'd1;
          end
        end
      end
      REQ_FLUSH: begin
        if (acc_count != 3'd0) begin
          fresh = '{acc_bits, 1'b0};
          expected_bytes.insert(expected_bytes.size(), fresh);
          acc_bits  = '0;
          acc_count = '0;
        end
      end
      default: ;
    endcase
    // mark the final byte of this transaction
    if (expected_bytes.size() > first_idx) begin
      expected_bytes[expected_bytes.size() - 1].last = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    packed_byte_t exp_byte;
    if (!rst_n) begin
      for (int k = 0; k < TABLE_SIZE; k++) begin
        len_table[k]  = '0;
        code_table[k] = '0;
      end
      acc_bits  = '0;
      acc_count = '0;
      expected_bytes.delete();
    end else begin
      if (in_tvalid && in_tready)
        pack_request(in_tuser, in_tdata[7:0], in_tdata[13:8], in_tdata[45:14]);
      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          $error("out_byte: expected none, actual %02h", out_tdata);
          error_count++;
        end else begin
          exp_byte = expected_bytes.pop_front();
          if (out_tdata !== exp_byte.data) begin
            $error("out_byte: expected %02h, actual %02h", exp_byte.data, out_tdata);
            error_count++;
          end
          if (out_tlast !== exp_byte.last) begin
            $error("last_of_run: expected %0b, actual %0b", exp_byte.last, out_tlast);
            error_count++;
          end
        end
      end
    end
    pending_count <= expected_bytes.size();
  end

endmodule

// ===== sim/prefix_code_bit_packer_test.sv =====
// Testbench top for the prefix-code bit packer: clock, reset, stimulus, watchdog, verdict.
module prefix_code_bit_packer_test;
  import pcbp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 256;
  localparam int RX_HOLD      = 150;
  localparam int DRAIN_CYCLES = 16;
  localparam int IDLE_LIMIT   = 2000;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;  // symbol, code_len, code_bits, zero pad
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;  // req_type
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // out_byte
  logic                   out_tlast;
  int                     error_count;
  int                     pending_count;
  int                     issued     = 0;
  int                     idle_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  prefix_code_bit_packer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  pcbp_byte_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  // Abort when no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("prefix_code_bit_packer_test: done, errors");
      $finish;
    end
  end

  // Receiver: ready bursts with short gaps, a few long ones, one long hold-off.
  initial begin : byte_sink
    int burst;
    int gap;
    bit held;
    held = 1'b0;
    @(posedge clk);
    forever begin
      burst = $urandom_range(40, 3);
      out_tready <= 1'b1;
      repeat (burst) @(posedge clk);
      if (!held && issued >= 60) begin
        held = 1'b1;
        gap  = RX_HOLD;
      end else if ($urandom_range(9, 0) == 0) begin
        gap = $urandom_range(40, 8);
      end else begin
        gap = $urandom_range(3, 1);
      end
      out_tready <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  end

  task automatic issue_request(input logic [1:0] req, input logic [SYM_W-1:0] sym,
                               input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] code);
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {2'b00, code, len, sym};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    issued++;
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      in_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [SYM_W-1:0]  live_syms[$];
    logic [1:0]        req;
    logic [SYM_W-1:0]  sym;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
    int                pick;
    int                gap;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, extremes, saturation, padding, empty flush
    issue_request(REQ_ENCODE, 8'd5, 6'd0, 32'h0);
    issue_request(REQ_FLUSH, 8'd0, 6'd0, 32'h0);
    issue_request(REQ_LOAD, 8'd0, 6'd32, 32'hFFFF_FFFF);
    issue_request(REQ_LOAD, 8'd255, 6'd1, 32'h0000_0001);
    issue_request(REQ_LOAD, 8'd1, 6'd63, 32'hA5A5_5A5A);
    issue_request(REQ_LOAD, 8'd2, 6'd3, 32'hFFFF_FFF5);
    issue_request(REQ_LOAD, 8'd3, 6'd0, 32'h1234_5678);
    issue_request(REQ_LOAD, 8'd4, 6'd33, 32'h0F0F_0F0F);
    issue_request(REQ_LOAD, 8'd5, 6'd8, 32'h0000_0000);
    issue_request(REQ_UNUSED, 8'hFF, 6'h3F, 32'hFFFF_FFFF);
    issue_request(REQ_ENCODE, 8'd0, 6'h3F, 32'hFFFF_FFFF);
    issue_request(REQ_ENCODE, 8'd255, 6'd0, 32'h0);
    issue_request(REQ_ENCODE, 8'd1, 6'd0, 32'h0);
    issue_request(REQ_ENCODE, 8'd2, 6'd0, 32'h0);
    issue_request(REQ_ENCODE, 8'd3, 6'd0, 32'h0);
    issue_request(REQ_FLUSH, 8'd0, 6'd0, 32'h0);
    issue_request(REQ_FLUSH, 8'd0, 6'd0, 32'h0);
    issue_request(REQ_ENCODE, 8'd4, 6'd0, 32'h0);
    repeat (6) issue_request(REQ_ENCODE, 8'd255, 6'd0, 32'h0);
    issue_request(REQ_FLUSH, 8'd0, 6'd0, 32'h0);
    live_syms = '{8'd0, 8'd255, 8'd1, 8'd2, 8'd4, 8'd5};

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(99, 0);
      sym  = SYM_W'($urandom_range(255, 0));
      len  = LEN_W'($urandom_range(63, 0));
      code = $urandom();
      if (pick < 15) begin
        req  = REQ_LOAD;
        pick = $urandom_range(19, 0);
        // mostly short codes, some long, a few over the limit or unused
        if (pick < 12)      len = LEN_W'($urandom_range(12, 1));
        else if (pick < 16) len = LEN_W'($urandom_range(32, 13));
        else if (pick < 18) len = LEN_W'($urandom_range(63, 33));
        else                len = '0;
        live_syms.insert(live_syms.size(), sym);
      end else if (pick < 85) begin
        req = REQ_ENCODE;
        if ($urandom_range(4, 0) != 0)
          sym = live_syms[$urandom_range(live_syms.size() - 1, 0)];
      end else if (pick < 97) begin
        req = REQ_FLUSH;
      end else begin
        req = REQ_UNUSED;
      end
      issue_request(req, sym, len, code);

      if (n == 150) begin
        in_tvalid <= 1'b0;
        wait_for_drain();
      end else if (n < 200 || n >= 240) begin
        pick = $urandom_range(99, 0);
        if (pick < 70)      gap = 0;
        else if (pick < 92) gap = $urandom_range(3, 1);
        else                gap = $urandom_range(30, 8);
        idle_sender(gap);
      end
    end

    in_tvalid <= 1'b0;
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("prefix_code_bit_packer_test: done, clean");
    end else begin
      $display("prefix_code_bit_packer_test: done, errors");
    end
    $finish;
  end

endmodule
